// ===== rtl/core/tlik_pkg.sv =====
// ============================================================================
// tlik_pkg: shared types, constants and helpers for the two-link IK unit
// Fixed-point formats, pipeline payload structs, CORDIC angle table and the
// pre-rotation / rounding helpers used by several modules.
// ============================================================================
package tlik_pkg;

    // Port field widths
    localparam int POS_W     = 16;
    localparam int LINK_W    = 15;
    localparam int SH_W      = 15;
    localparam int EL_W      = 16;
    localparam int CFG_IDX_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LINK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK = 8'd1;

    localparam logic [LINK_W-1:0] LOWER_LINK_RESET = 15'd5202;
    localparam logic [LINK_W-1:0] UPPER_LINK_RESET = 15'd6658;

    // Angle format
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ACC_FRAC        = 30;
    localparam int CORDIC_STAGES   = 16;
    localparam int STG_W           = 5;
    localparam int RND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;

    // Internal datapath widths
    localparam int SQ_W    = 32;   // squares of positions
    localparam int LEN_W   = 31;   // 2*L1*L2 and |num|
    localparam int NUM_W   = 34;   // num and a, signed
    localparam int RAD_W   = 62;   // radicand of the square root
    localparam int ROOT_W  = 31;
    localparam int SQ_STEPS = 31;  // one root bit per cell
    localparam int CW      = 52;   // CORDIC x/y
    localparam int ZW      = 34;   // CORDIC angle accumulator
    localparam int ANG_W   = ZW - RND_SHIFT;

    localparam logic signed [ZW-1:0] HALF_PI_ACC = 34'sd1686629713;
    localparam longint SHOULDER_MAX_ACC = 64'd2529944570;
    localparam logic signed [ANG_W-1:0] SHOULDER_LIMIT =
        ANG_W'((SHOULDER_MAX_ACC + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cvec_t;

    typedef struct packed {
        logic                    ok;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] a;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0] v;
        logic [RAD_W-1:0] r;
    } sqrt_t;

    typedef struct packed {
        logic  ok;
        cvec_t el;
        cvec_t sh0;
        cvec_t sh1;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_step(input logic [STG_W-1:0] i);
        logic [ZW-1:0] one;
        one = ZW'(1);
        case (i)
            5'd0:    return 34'sd843314857;
            5'd1:    return 34'sd497837829;
            5'd2:    return 34'sd263043837;
            5'd3:    return 34'sd133525159;
            5'd4:    return 34'sd67021687;
            5'd5:    return 34'sd33543516;
            5'd6:    return 34'sd16775851;
            5'd7:    return 34'sd8388437;
            5'd8:    return 34'sd4194283;
            5'd9:    return 34'sd2097149;
            5'd31:   return '0;
            default: return $signed(one << (5'd30 - i));
        endcase
    endfunction

    // Fold the left half plane into the right one by a quarter turn.
    function automatic cvec_t prerot(input logic signed [CW-1:0] y,
                                     input logic signed [CW-1:0] x);
        cvec_t v;
        v.x = x;
        v.y = y;
        v.z = '0;
        if (x < 0) begin
            if (y >= 0) begin
                v.x = y;
                v.y = -x;
                v.z = HALF_PI_ACC;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -HALF_PI_ACC;
            end
        end
        return v;
    endfunction

    function automatic logic signed [ANG_W-1:0] to_angle(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] t;
        t = z + $signed(ZW'(1) << (RND_SHIFT - 1));
        return ANG_W'(t >>> RND_SHIFT);
    endfunction

endpackage

// ===== rtl/core/tlik_item_if.sv =====
// ============================================================================
// tlik_item_if: target point channel
// Valid/ready channel carrying one target point per beat.
// ============================================================================
interface tlik_item_if import tlik_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;

    modport source (output valid, target_x, target_y, input ready);
    modport sink   (input valid, target_x, target_y, output ready);
endinterface

// ===== rtl/core/tlik_result_if.sv =====
// ============================================================================
// tlik_result_if: joint angle channel
// Valid/ready channel carrying one solution per beat.
// ============================================================================
interface tlik_result_if import tlik_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   reachable;
    logic [SH_W-1:0]        shoulder_angle;
    logic signed [EL_W-1:0] elbow_angle;

    modport source (output valid, reachable, shoulder_angle, elbow_angle, input ready);
    modport sink   (input valid, reachable, shoulder_angle, elbow_angle, output ready);
endinterface

// ===== rtl/core/tlik_cfg_if.sv =====
// ============================================================================
// tlik_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ============================================================================
interface tlik_cfg_if import tlik_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [LINK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tlik_front.sv =====
// ============================================================================
// tlik_front: law-of-cosines front end
// Four stages: squares, num/den and reach check, squares of den and |num|,
// radicand for the sine magnitude.
// ============================================================================
module tlik_front import tlik_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic signed [POS_W-1:0] x,
    input  logic signed [POS_W-1:0] y,
    input  logic [LINK_W-1:0]       l1,
    input  logic [LINK_W-1:0]       l2,
    output logic                    out_valid,
    output sqrt_t                   out_sq,
    output side_t                   out_side
);

    logic [3:0] valid_reg, valid_next;

    // stage 1
    logic signed [POS_W-1:0]  p1_x_reg, p1_y_reg;
    logic [SQ_W-1:0]          p1_xx_reg, p1_yy_reg, p1_xx_next, p1_yy_next;
    logic [2*LINK_W-1:0]      p1_l1sq_reg, p1_l2sq_reg, p1_l12_reg;
    logic [2*LINK_W-1:0]      p1_l1sq_next, p1_l2sq_next, p1_l12_next;
    logic signed [SQ_W-1:0]   xs, ys;

    // stage 2
    side_t                    p2_side_reg, p2_side_next;
    logic [LEN_W-1:0]         p2_den_reg, p2_den_next;
    logic signed [NUM_W-1:0]  r2_s, l1sq_s, l2sq_s, den_s;

    // stage 3
    side_t                    p3_side_reg;
    logic [RAD_W-1:0]         p3_den2_reg, p3_num2_reg, p3_den2_next, p3_num2_next;
    logic [LEN_W-1:0]         anum;

    // stage 4
    side_t                    p4_side_reg;
    logic [RAD_W-1:0]         p4_rad_reg, p4_rad_next;

    always_comb
    begin
        xs           = SQ_W'(x);
        ys           = SQ_W'(y);
        p1_xx_next   = $unsigned(xs * xs);
        p1_yy_next   = $unsigned(ys * ys);
        p1_l1sq_next = (2*LINK_W)'(l1) * (2*LINK_W)'(l1);
        p1_l2sq_next = (2*LINK_W)'(l2) * (2*LINK_W)'(l2);
        p1_l12_next  = (2*LINK_W)'(l1) * (2*LINK_W)'(l2);
    end

    always_comb
    begin
        r2_s   = $signed(NUM_W'(p1_xx_reg) + NUM_W'(p1_yy_reg));
        l1sq_s = $signed(NUM_W'(p1_l1sq_reg));
        l2sq_s = $signed(NUM_W'(p1_l2sq_reg));
        den_s  = $signed(NUM_W'({p1_l12_reg, 1'b0}));
        p2_den_next      = LEN_W'({p1_l12_reg, 1'b0});
        p2_side_next.x   = p1_x_reg;
        p2_side_next.y   = p1_y_reg;
        p2_side_next.num = r2_s - l1sq_s - l2sq_s;
        p2_side_next.a   = r2_s + l1sq_s - l2sq_s;
        p2_side_next.ok  = (r2_s != '0) && (den_s != '0) &&
                           (p2_side_next.num <= den_s) && (p2_side_next.num >= -den_s);
    end

    always_comb
    begin
        // out-of-range points drop |num| to zero so the radicand stays non-negative
        if (!p2_side_reg.ok)
            anum = '0;
        else if (p2_side_reg.num[NUM_W-1])
            anum = LEN_W'(-p2_side_reg.num);
        else
            anum = LEN_W'(p2_side_reg.num);
        p3_den2_next = RAD_W'(p2_den_reg) * RAD_W'(p2_den_reg);
        p3_num2_next = RAD_W'(anum) * RAD_W'(anum);
        p4_rad_next  = p3_den2_reg - p3_num2_reg;
    end

    always_comb
    begin
        valid_next = adv ? {valid_reg[2:0], in_valid} : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_x_reg    <= x;
            p1_y_reg    <= y;
            p1_xx_reg   <= p1_xx_next;
            p1_yy_reg   <= p1_yy_next;
            p1_l1sq_reg <= p1_l1sq_next;
            p1_l2sq_reg <= p1_l2sq_next;
            p1_l12_reg  <= p1_l12_next;
            p2_side_reg <= p2_side_next;
            p2_den_reg  <= p2_den_next;
            p3_side_reg <= p2_side_reg;
            p3_den2_reg <= p3_den2_next;
            p3_num2_reg <= p3_num2_next;
            p4_side_reg <= p3_side_reg;
            p4_rad_reg  <= p4_rad_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_sq.v  = p4_rad_reg;
    assign out_sq.r  = '0;
    assign out_side  = p4_side_reg;

endmodule

// ===== rtl/core/tlik_sqrt_cell.sv =====
// ============================================================================
// tlik_sqrt_cell: one bit of the integer square root
// Restoring step: try the current root bit, keep it if the remainder allows.
// ============================================================================
module tlik_sqrt_cell import tlik_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [RAD_W-1:0] bit_val,
    input  logic             in_valid,
    input  sqrt_t            in_sq,
    input  side_t            in_side,
    output logic             out_valid,
    output sqrt_t            out_sq,
    output side_t            out_side
);

    logic           valid_reg;
    sqrt_t          sq_reg, sq_next;
    side_t          side_reg;
    logic [RAD_W:0] trial;

    always_comb
    begin
        trial = {1'b0, in_sq.r} + {1'b0, bit_val};
        if ({1'b0, in_sq.v} >= trial)
        begin
            sq_next.v = in_sq.v - trial[RAD_W-1:0];
            sq_next.r = (in_sq.r >> 1) + bit_val;
        end
        else
        begin
            sq_next.v = in_sq.v;
            sq_next.r = in_sq.r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg   <= sq_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_sq    = sq_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/tlik_vec.sv =====
// ============================================================================
// tlik_vec: CORDIC operand builder
// Forms the elbow vector and both shoulder vectors, then pre-rotates them.
// ============================================================================
module tlik_vec import tlik_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] root,
    input  side_t             in_side,
    output logic              out_valid,
    output cord_t             out_cord
);

    logic [1:0]           valid_reg;
    logic                 v1_ok_reg;
    logic signed [CW-1:0] v1_s_reg, v1_num_reg;
    logic signed [CW-1:0] v1_ay_reg, v1_sx_reg, v1_ax_reg, v1_sy_reg;
    logic signed [CW-1:0] s_w, a_w, x_w, y_w;
    cord_t                cord_reg, cord_next;

    always_comb
    begin
        s_w = $signed(CW'(root));
        a_w = CW'(in_side.a);
        x_w = CW'(in_side.x);
        y_w = CW'(in_side.y);
    end

    always_comb
    begin
        cord_next.ok  = v1_ok_reg;
        cord_next.el  = prerot(v1_s_reg, v1_num_reg);
        cord_next.sh0 = prerot(v1_ay_reg - v1_sx_reg, v1_ax_reg + v1_sy_reg);
        cord_next.sh1 = prerot(v1_ay_reg + v1_sx_reg, v1_ax_reg - v1_sy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_ok_reg  <= in_side.ok;
            v1_s_reg   <= s_w;
            v1_num_reg <= CW'(in_side.num);
            v1_ay_reg  <= a_w * y_w;
            v1_sx_reg  <= s_w * x_w;
            v1_ax_reg  <= a_w * x_w;
            v1_sy_reg  <= s_w * y_w;
            cord_reg   <= cord_next;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_cord  = cord_reg;

endmodule

// ===== rtl/core/tlik_cordic_cell.sv =====
// ============================================================================
// tlik_cordic_cell: one vectoring CORDIC iteration on three lanes
// Elbow, shoulder positive-sine and shoulder negative-sine vectors.
// ============================================================================
module tlik_cordic_cell import tlik_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic [STG_W-1:0] stage,
    input  logic             in_valid,
    input  cord_t            in_cord,
    output logic             out_valid,
    output cord_t            out_cord
);

    logic  valid_reg;
    cord_t cord_reg, cord_next;

    function automatic cvec_t rotate(input cvec_t v, input logic [STG_W-1:0] i);
        cvec_t                o;
        logic signed [CW-1:0] dx, dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (v.y >= 0)
        begin
            o.x = v.x + dx;
            o.y = v.y - dy;
            o.z = v.z + atan_step(i);
        end
        else
        begin
            o.x = v.x - dx;
            o.y = v.y + dy;
            o.z = v.z - atan_step(i);
        end
        return o;
    endfunction

    always_comb
    begin
        cord_next.ok  = in_cord.ok;
        cord_next.el  = rotate(in_cord.el, stage);
        cord_next.sh0 = rotate(in_cord.sh0, stage);
        cord_next.sh1 = rotate(in_cord.sh1, stage);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            cord_reg <= cord_next;
    end

    assign out_valid = valid_reg;
    assign out_cord  = cord_reg;

endmodule

// ===== rtl/core/two_link_planar_inverse_kinematics_unit.sv =====
// ============================================================================
// two_link_planar_inverse_kinematics_unit: two-link planar arm IK solver
// Shoulder and elbow angles for a target point, link lengths in registers.
// ============================================================================
// Usage:
//   target  - sink channel, one beat per target point (Q0.15 metres).
//   result  - source channel, one beat per target: reachable flag, shoulder
//             angle (UQ2.13) and elbow angle (Q3.13), in radians, both zero if unreachable.
//   cfg     - register writes, always ready. Index 0 is the lower link length,
//             index 1 the upper link length; other indexes are ignored. Write
//             only while no target is in flight.
// From target beat to result beat a point passes 4 front-end stages,
// 31 square-root cells (one root bit each), 2 operand stages, 16 CORDIC cells
// and the output register. Throughput is one target per cycle while the output
// is not stalled, as every cell then hands its payload to the next one each cycle.
// When the receiver stalls with a result held in the output register, the
// whole chain freezes and target.ready drops in the same cycle; it rises
// again in the cycle that result.ready is seen high.
// Reset clears all valid bits and loads the link lengths with 5202 and 6658.
// ============================================================================
module two_link_planar_inverse_kinematics_unit import tlik_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    tlik_cfg_if.sink      cfg,
    tlik_item_if.sink     target,
    tlik_result_if.source result
);

    // global advance: move every stage unless a result is stuck at the output
    logic adv;

    // link length registers
    logic [LINK_W-1:0] lower_link_reg, lower_link_next;
    logic [LINK_W-1:0] upper_link_reg, upper_link_next;

    // front end
    logic  fe_valid;
    sqrt_t fe_sq;
    side_t fe_side;

    // square-root chain, index 0 is the chain input
    logic [SQ_STEPS:0] sq_valid;
    sqrt_t             sq_data [SQ_STEPS+1];
    side_t             sq_side [SQ_STEPS+1];

    // CORDIC chain
    logic [CORDIC_STAGES:0] cq_valid;
    cord_t                  cq_data [CORDIC_STAGES+1];

    // output stage
    logic                    res_valid_reg, res_valid_next;
    logic                    res_reachable_reg, res_reachable_next;
    logic [SH_W-1:0]         res_shoulder_reg, res_shoulder_next;
    logic signed [EL_W-1:0]  res_elbow_reg, res_elbow_next;
    logic signed [ANG_W-1:0] el_pos, sh0, sh1;
    logic                    br0_ok, br1_ok;
    cord_t                   fin;

    assign adv          = !res_valid_reg || result.ready;
    assign target.ready = adv;
    assign cfg.ready    = 1'b1;

    // ---- configuration ----
    always_comb
    begin
        lower_link_next = lower_link_reg;
        upper_link_next = upper_link_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LOWER_LINK: lower_link_next = cfg.data;
                REG_UPPER_LINK: upper_link_next = cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_link_reg <= LOWER_LINK_RESET;
            upper_link_reg <= UPPER_LINK_RESET;
        end
        else
        begin
            lower_link_reg <= lower_link_next;
            upper_link_reg <= upper_link_next;
        end
    end

    // ---- law of cosines and radicand ----
    tlik_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (target.valid),
        .x        (target.target_x),
        .y        (target.target_y),
        .l1       (lower_link_reg),
        .l2       (upper_link_reg),
        .out_valid(fe_valid),
        .out_sq   (fe_sq),
        .out_side (fe_side)
    );

    assign sq_valid[0] = fe_valid;
    assign sq_data[0]  = fe_sq;
    assign sq_side[0]  = fe_side;

    // ---- square root, most significant root bit first ----
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam int BIT_POS = 2 * (SQ_STEPS - 1 - k);
        tlik_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .bit_val  (RAD_W'(1) << BIT_POS),
            .in_valid (sq_valid[k]),
            .in_sq    (sq_data[k]),
            .in_side  (sq_side[k]),
            .out_valid(sq_valid[k+1]),
            .out_sq   (sq_data[k+1]),
            .out_side (sq_side[k+1])
        );
    end

    // ---- operand build and pre-rotation ----
    tlik_vec u_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (sq_valid[SQ_STEPS]),
        .root     (sq_data[SQ_STEPS].r[ROOT_W-1:0]),
        .in_side  (sq_side[SQ_STEPS]),
        .out_valid(cq_valid[0]),
        .out_cord (cq_data[0])
    );

    // ---- CORDIC vectoring, one iteration per cell ----
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        tlik_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .stage    (STG_W'(k)),
            .in_valid (cq_valid[k]),
            .in_cord  (cq_data[k]),
            .out_valid(cq_valid[k+1]),
            .out_cord (cq_data[k+1])
        );
    end

    // ---- joint limits and branch choice ----
    assign fin = cq_data[CORDIC_STAGES];

    always_comb
    begin
        el_pos = to_angle(fin.el.z);
        sh0    = to_angle(fin.sh0.z);
        sh1    = to_angle(fin.sh1.z);
        // positive-sine branch uses +elbow, negative-sine branch -elbow
        br0_ok = (sh0 >= 0) && (sh0 <= SHOULDER_LIMIT) && (el_pos <= 0);
        br1_ok = (sh1 >= 0) && (sh1 <= SHOULDER_LIMIT) && (el_pos >= 0);

        res_reachable_next = 1'b0;
        res_shoulder_next  = '0;
        res_elbow_next     = '0;
        if (fin.ok && br0_ok)
        begin
            res_reachable_next = 1'b1;
            res_shoulder_next  = sh0[SH_W-1:0];
            res_elbow_next     = el_pos[EL_W-1:0];
        end
        else if (fin.ok && br1_ok)
        begin
            res_reachable_next = 1'b1;
            res_shoulder_next  = sh1[SH_W-1:0];
            res_elbow_next     = EL_W'(-el_pos);
        end
        res_valid_next = adv ? cq_valid[CORDIC_STAGES] : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    // hold the payload while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reachable_reg <= res_reachable_next;
            res_shoulder_reg  <= res_shoulder_next;
            res_elbow_reg     <= res_elbow_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.reachable      = res_reachable_reg;
    assign result.shoulder_angle = res_shoulder_reg;
    assign result.elbow_angle    = res_elbow_reg;

    // ---- assertions ----
    a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(sq_valid) && $stable(cq_valid))
        else $error("pipeline moved while output stalled");

    a_unreach_drop: assert property (@(posedge clk) disable iff (!rst_n)
        adv && cq_valid[CORDIC_STAGES] && !fin.ok |=> !res_reachable_reg)
        else $error("out-of-range point reported reachable");

    a_limits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reachable_reg |->
        ($signed({1'b0, res_shoulder_reg}) <= SHOULDER_LIMIT) && (res_elbow_reg <= 0))
        else $error("reachable result outside joint limits");

    a_zero_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reachable_reg |->
        (res_shoulder_reg == '0) && (res_elbow_reg == '0))
        else $error("unreachable result carries nonzero angles");

endmodule

// ===== bench/tlik_tb_pkg.sv =====
// ============================================================================
// tlik_tb_pkg: solution predictor for the two-link IK bench
// Exact-integer law-of-cosines solver with a vectoring CORDIC for atan2.
// ============================================================================
package tlik_tb_pkg;
    import tlik_pkg::*;

    typedef struct {
        bit                    reachable;
        bit [SH_W-1:0]         shoulder_angle;
        bit signed [EL_W-1:0]  elbow_angle;
    } joint_sol_t;

    localparam longint HALF_PI_Z = 64'sd1686629713;
    localparam longint SH_MAX_Z  = 64'sd2529944570;

    function automatic longint arc_step(int i);
        longint tab [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tab[i];
        if (i <= ACC_FRAC)
            return longint'(1) << (ACC_FRAC - i);
        return 0;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = HALF_PI_Z;
            end
            else
            begin
                x = -y; y = t; z = -HALF_PI_Z;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += arc_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= arc_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint round_angle(longint z);
        return (z + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;
    endfunction

    function automatic joint_sol_t solve_joints(logic signed [POS_W-1:0] tx,
                                                logic signed [POS_W-1:0] ty,
                                                logic [LINK_W-1:0] len1,
                                                logic [LINK_W-1:0] len2);
        joint_sol_t sol;
        longint x, y, l1, l2, r2, den, num, an, s, el_pos, lim, b, sh, el, mag;
        sol = '{0, 0, 0};
        x = tx; y = ty; l1 = len1; l2 = len2;
        r2 = x * x + y * y;
        den = 2 * l1 * l2;
        if (r2 == 0 || den == 0)
            return sol;
        num = r2 - l1 * l1 - l2 * l2;
        if (num > den || num < -den)
            return sol;
        mag = num < 0 ? -num : num;
        s = root_floor(longint'(den * den - mag * mag));
        el_pos = round_angle(vector_angle(s, num));
        an = 2 * l1 * l1 + num;
        lim = round_angle(SH_MAX_Z);
        for (int br = 0; br < 2; br++)
        begin
            b = br == 0 ? s : -s;
            sh = round_angle(vector_angle(an * y - b * x, an * x + b * y));
            el = br == 0 ? el_pos : -el_pos;
            if (sh >= 0 && sh <= lim && el <= 0)
            begin
                sol.reachable = 1;
                sol.shoulder_angle = sh[SH_W-1:0];
                sol.elbow_angle = el[EL_W-1:0];
                return sol;
            end
        end
        return sol;
    endfunction
endpackage

// ===== bench/tlik_checker.sv =====
// ============================================================================
// tlik_checker: scoreboard for the two-link IK unit
// Tracks register writes, predicts each target's solution and compares beats.
// ============================================================================
module tlik_checker
    import tlik_pkg::*;
    import tlik_tb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tlik_cfg_if.sink      cfg_mon,
    tlik_item_if.sink     tgt_mon,
    tlik_result_if.sink   res_mon,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LINK_W-1:0] lower_len = LOWER_LINK_RESET;
    logic [LINK_W-1:0] upper_len = UPPER_LINK_RESET;
    joint_sol_t        expected_sols[$];

    initial fail_count = 0;
    assign pending = expected_sols.size();

    always @(posedge clk)
    begin
        joint_sol_t want;
        if (rst_n)
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == REG_LOWER_LINK)
                    lower_len <= cfg_mon.data;
                else if (cfg_mon.index == REG_UPPER_LINK)
                    upper_len <= cfg_mon.data;
            end
            if (tgt_mon.valid && tgt_mon.ready)
                expected_sols.push_back(solve_joints(tgt_mon.target_x, tgt_mon.target_y,
                                                     lower_len, upper_len));
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_sols.size() == 0)
                begin
                    $display("%0t: unexpected result beat", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = expected_sols.pop_front();
                    if (want.reachable !== res_mon.reachable
                        || want.shoulder_angle !== res_mon.shoulder_angle
                        || want.elbow_angle !== res_mon.elbow_angle)
                    begin
                        $display("%0t: expected r=%0d sh=%0d el=%0d, got r=%0d sh=%0d el=%0d",
                                 $realtime, want.reachable, want.shoulder_angle,
                                 want.elbow_angle, res_mon.reachable,
                                 res_mon.shoulder_angle, res_mon.elbow_angle);
                        fail_count++;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/two_link_planar_inverse_kinematics_unit_tb.sv =====
// ============================================================================
// two_link_planar_inverse_kinematics_unit_tb: two-link IK unit testbench
// Drives directed and random target points across several link-length
// settings with random gaps and back-pressure; a checker module scores beats.
// ============================================================================
module two_link_planar_inverse_kinematics_unit_tb;
    import tlik_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 54;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   hold_off;   // long receiver stall, raised by the stimulus thread

    tlik_cfg_if    cfg_ch();
    tlik_item_if   tgt_ch();
    tlik_result_if res_ch();

    two_link_planar_inverse_kinematics_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .target (tgt_ch.sink),
        .result (res_ch.source)
    );

    tlik_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_mon    (cfg_ch.sink),
        .tgt_mon    (tgt_ch.sink),
        .res_mon    (res_ch.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Hard stop: ~800 targets plus stalls fit well inside.
    initial
    begin
        #20ms;
        $display("two_link_planar_inverse_kinematics_unit_tb: FAIL");
        $finish;
    end

    // Send one target beat: draw a gap, then hold valid until it is taken.
    // Valid stays high after the beat so the next target can follow at once.
    task automatic send_target(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            tgt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tgt_ch.valid    <= 1'b1;
        tgt_ch.target_x <= x;
        tgt_ch.target_y <= y;
        do @(posedge clk); while (!tgt_ch.ready);
    endtask

    // Drop valid after the last target of a burst.
    task automatic idle_target();
        tgt_ch.valid <= 1'b0;
    endtask

    // Wait for every result, then let the pipe drain before touching registers.
    task automatic drain_pipe();
        idle_target();
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_link(logic [CFG_IDX_W-1:0] idx, logic [LINK_W-1:0] len);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= len;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly points near the reachable annulus, some anywhere in the plane.
    task automatic send_random(int count, int span);
        int   rx;
        int   ry;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                rx = int'($urandom_range(0, 65535)) - 32768;
                ry = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                rx = int'($urandom_range(0, 2 * span)) - span;
                ry = int'($urandom_range(0, 2 * span)) - span;
                if ($urandom_range(0, 1))
                    rx = rx < 0 ? -rx : rx;    // favor the forward half
                if (rx > 32767) rx = 32767;
                if (ry > 32767) ry = 32767;
                if (rx < -32768) rx = -32768;
                if (ry < -32768) ry = -32768;
            end
            send_target(rx[15:0], ry[15:0]);
        end
    endtask

    // Receiver: random stall per beat, plus the long hold-off on request.
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                stall = $urandom_range(0, 4) == 0 ? $urandom_range(0, 8) : 0;
                if (stall != 0)
                begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Long receiver stall counted in its own process.
    task automatic stall_receiver(int cycles);
        hold_off = 1;
        repeat (cycles) @(posedge clk);
        hold_off = 0;
    endtask

    initial
    begin
        hold_off        = 0;
        rst_n           = 1'b0;
        tgt_ch.valid    = 1'b0;
        tgt_ch.target_x = '0;
        tgt_ch.target_y = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_LOWER_LINK;
        cfg_ch.data     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: origin, field extremes, the straight arm, folded arm.
        send_target(16'sd0, 16'sd0);
        send_target(16'sd32767, 16'sd0);
        send_target(-16'sd32768, -16'sd32768);
        send_target(16'sd32767, 16'sd32767);
        send_target(-16'sd32768, 16'sd32767);
        send_target(16'sd11860, 16'sd0);       // fully stretched
        send_target(16'sd0, 16'sd11860);
        send_target(16'sd1456, 16'sd0);        // fully folded
        send_target(16'sd6000, 16'sd6000);
        send_target(-16'sd6000, 16'sd6000);
        send_target(16'sd6000, -16'sd6000);
        send_target(-16'sd6000, -16'sd6000);
        send_target(16'sd1, 16'sd0);
        send_target(16'sd0, -16'sd1);
        send_target(16'sd8000, 16'sd2000);
        send_random(150, 13000);
        drain_pipe();

        // Zero link length: everything unreachable.
        write_link(REG_LOWER_LINK, '0);
        send_target(16'sd6658, 16'sd0);
        send_random(20, 13000);
        drain_pipe();

        // Largest links, then the smallest, then an index past the map.
        write_link(REG_LOWER_LINK, 15'h7FFF);
        write_link(REG_UPPER_LINK, 15'h7FFF);
        send_target(16'sd32767, 16'sd32767);
        send_target(-16'sd32768, 16'sd0);
        send_random(120, 32767);
        drain_pipe();

        write_link(REG_LOWER_LINK, 15'd1);
        write_link(REG_UPPER_LINK, 15'd1);
        write_link(8'hFF, 15'd4000);           // must be ignored
        send_target(16'sd2, 16'sd0);
        send_target(16'sd1, 16'sd1);
        send_target(16'sd0, 16'sd1);
        send_random(60, 3);
        drain_pipe();

        write_link(REG_LOWER_LINK, 15'd16384);
        write_link(REG_UPPER_LINK, 15'd9000);
        fork
            stall_receiver(200);
            send_random(120, 26000);
        join
        drain_pipe();

        write_link(REG_LOWER_LINK, 15'd7000);
        write_link(REG_UPPER_LINK, 15'd21845);
        send_random(120, 29000);
        // Sender pause until every result is back.
        idle_target();
        while (pending != 0)
            @(posedge clk);
        send_random(110, 29000);
        drain_pipe();

        if (fail_count == 0)
            $display("two_link_planar_inverse_kinematics_unit_tb: PASS");
        else
            $display("two_link_planar_inverse_kinematics_unit_tb: FAIL");
        $finish;
    end
endmodule

// ===== two_link_planar_inverse_kinematics_unit.f =====
rtl/core/tlik_pkg.sv
rtl/core/tlik_item_if.sv
rtl/core/tlik_result_if.sv
rtl/core/tlik_cfg_if.sv
rtl/core/tlik_front.sv
rtl/core/tlik_sqrt_cell.sv
rtl/core/tlik_vec.sv
rtl/core/tlik_cordic_cell.sv
rtl/core/two_link_planar_inverse_kinematics_unit.sv
bench/tlik_tb_pkg.sv
bench/tlik_checker.sv
bench/two_link_planar_inverse_kinematics_unit_tb.sv
